// ===== src/watershed_region_labeler_3d_core_macros.svh =====
// Assertion macros shared by the labeler RTL.
`ifndef WATERSHED_REGION_LABELER_3D_CORE_MACROS_SVH
`define WATERSHED_REGION_LABELER_3D_CORE_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define WRL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("watershed labeler check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define WRL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("watershed labeler check failed");
`else
`define WRL_ASSERT_IMP(lbl, ante, cons)
`define WRL_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/wrl3d_pkg.sv =====
package wrl3d_pkg;

  // Sizing of the volume and the stored samples.
  localparam int MAX_EXTENT  = 16;
  localparam int MAX_VOXELS  = 4096;
  localparam int SAMPLE_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_VOXELS);
  localparam int CNT_W   = IDX_W + 1;
  localparam int ADDR_W  = IDX_W + 2;
  localparam int COORD_W = $clog2(MAX_EXTENT);
  localparam int EXT_W   = $clog2(MAX_EXTENT + 1);

  // Fixed field widths of the ports.
  localparam int CFG_EXT_W = 5;
  localparam int THR_W     = 16;
  localparam int VIDX_W    = 12;
  localparam int VAL_W     = 16;
  localparam int LABEL_W   = 13;
  localparam int CMP_W     = SAMPLE_BITS + THR_W;

  // Commands.
  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_COMPUTE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SIZE_SLOW = 2'd0;
  localparam logic [1:0] CFG_SIZE_MID  = 2'd1;
  localparam logic [1:0] CFG_SIZE_FAST = 2'd2;
  localparam logic [1:0] CFG_THRESHOLD = 2'd3;

  // Neighbor offset codes along one axis.
  localparam logic [1:0] OFF_NEG  = 2'd0;
  localparam logic [1:0] OFF_ZERO = 2'd1;
  localparam logic [1:0] OFF_POS  = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [VIDX_W-1:0] voxel_index;
    logic [VAL_W-1:0]  sample_value;
  } in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic [LABEL_W-1:0] region_count;
    logic               status;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_P1_CTR,
    ST_P1_NBR,
    ST_P1_LAST,
    ST_CLEAR,
    ST_P3_START,
    ST_P3_CHK,
    ST_P3_CHASE,
    ST_P3_ROOT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_CTR,
    PEND_NBR
  } pend_t;

  // An extent register of zero acts as one, a large one saturates.
  function automatic logic [EXT_W-1:0] clamp_ext(input logic [CFG_EXT_W-1:0] r);
    logic [EXT_W-1:0] e;
    if (r == '0) begin
      e = EXT_W'(1);
    end else if (32'(r) > MAX_EXTENT) begin
      e = EXT_W'(MAX_EXTENT);
    end else begin
      e = EXT_W'(r);
    end
    return e;
  endfunction

  function automatic logic below_thr(input logic [SAMPLE_BITS-1:0] s,
                                     input logic [THR_W-1:0] t);
    return CMP_W'(s) < CMP_W'(t);
  endfunction

endpackage

// ===== src/wrl3d_ram.sv =====
module wrl3d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/watershed_region_labeler_3d_core.sv =====
// Steepest-ascent region labeler for a volume of up to 16 x 16 x 16 voxels. A sample write,
// an out-of-volume access and a label read each give one result beat. A compute command
// keeps the block busy: it visits every voxel and reads its sample and its 27 neighborhood
// positions through the single sample memory port, then clears the root table, then follows
// each voxel's uphill chain one link per cycle through the uphill memory and looks up the
// root's region number. Labels become valid only after the first compute, and a read uses
// the labels of the last compute.
`include "watershed_region_labeler_3d_core_macros.svh"
module watershed_region_labeler_3d_core
  import wrl3d_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_t                  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_t                 out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [THR_W-1:0]     cfg_data
);

  state_t state_r, state_nxt;

  logic [CFG_EXT_W-1:0] size_slow_r, size_mid_r, size_fast_r;
  logic [THR_W-1:0]     thr_r;
  logic [LABEL_W-1:0]   regions_r, regions_nxt;
  out_t                 out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic [COORD_W-1:0] a_r, a_nxt, b_r, b_nxt, d_r, d_nxt;
  logic [IDX_W-1:0]   vidx_r, vidx_nxt;
  logic [1:0]         o0_r, o0_nxt, o1_r, o1_nxt, o2_r, o2_nxt;
  pend_t              pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_addr_r, pend_addr_nxt;
  logic [IDX_W-1:0]   best_r, best_nxt;
  logic [SAMPLE_BITS-1:0] bestv_r, bestv_nxt;
  logic               below_r, below_nxt;
  logic [CNT_W-1:0]   i_r, i_nxt;
  logic [IDX_W-1:0]   r_r, r_nxt;
  logic [LABEL_W-1:0] c_r, c_nxt;

  // Memory ports.
  logic                   s_we;
  logic [IDX_W-1:0]       s_waddr, s_raddr;
  logic [SAMPLE_BITS-1:0] s_wdata, s_rdata;
  logic                   u_we;
  logic [IDX_W-1:0]       u_waddr, u_raddr, u_wdata, u_rdata;
  logic                   rt_we;
  logic [IDX_W-1:0]       rt_waddr, rt_raddr;
  logic [LABEL_W-1:0]     rt_wdata, rt_rdata;
  logic                   l_we;
  logic [IDX_W-1:0]       l_waddr, l_raddr;
  logic [LABEL_W-1:0]     l_wdata, l_rdata;

  // Effective extents, plane size and voxel count.
  logic [EXT_W-1:0]   e_slow, e_mid, e_fast;
  logic [2*EXT_W-1:0] plane;
  logic [3*EXT_W-1:0] vol_full;
  logic [CNT_W-1:0]   vol;

  assign e_slow   = clamp_ext(size_slow_r);
  assign e_mid    = clamp_ext(size_mid_r);
  assign e_fast   = clamp_ext(size_fast_r);
  assign plane    = {{EXT_W{1'b0}}, e_mid} * {{EXT_W{1'b0}}, e_fast};
  assign vol_full = {{EXT_W{1'b0}}, plane} * {{(2*EXT_W){1'b0}}, e_slow};
  assign vol      = vol_full[CNT_W-1:0];

  logic in_fire, in_vol;
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign in_fire   = in_valid && in_ready;
  assign in_vol    = CNT_W'(in_data.voxel_index) < vol;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Neighbor position checks and address.
  function automatic logic nbr_in(input logic [COORD_W-1:0] p, input logic [1:0] o,
                                  input logic [EXT_W-1:0] n);
    logic ok;
    case (o)
      OFF_NEG: ok = (p != '0);
      OFF_POS: ok = (EXT_W'(p) + EXT_W'(1)) < n;
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  function automatic logic [ADDR_W-1:0] step(input logic [1:0] o,
                                             input logic [ADDR_W-1:0] stride);
    logic [ADDR_W-1:0] s;
    case (o)
      OFF_NEG: s = -stride;
      OFF_POS: s = stride;
      default: s = '0;
    endcase
    return s;
  endfunction

  logic              nbr_ok, o_last, vox_last, i_last, d_last, b_last;
  logic [ADDR_W-1:0] jsum;
  logic [IDX_W-1:0]  jaddr;

  assign nbr_ok = nbr_in(a_r, o0_r, e_slow) && nbr_in(b_r, o1_r, e_mid) &&
                  nbr_in(d_r, o2_r, e_fast);
  assign jsum   = ADDR_W'(vidx_r) + step(o0_r, ADDR_W'(plane)) +
                  step(o1_r, ADDR_W'(e_fast)) + step(o2_r, ADDR_W'(1));
  assign jaddr  = jsum[IDX_W-1:0];
  assign o_last = (o0_r == OFF_POS) && (o1_r == OFF_POS) && (o2_r == OFF_POS);
  assign vox_last = (CNT_W'(vidx_r) + CNT_W'(1)) == vol;
  assign i_last   = (i_r + CNT_W'(1)) == vol;
  assign d_last   = (EXT_W'(d_r) + EXT_W'(1)) == e_fast;
  assign b_last   = (EXT_W'(b_r) + EXT_W'(1)) == e_mid;

  // Fold the sample that returned this cycle into the running best.
  logic [IDX_W-1:0]       cur_best;
  logic [SAMPLE_BITS-1:0] cur_bestv;
  logic                   cur_below;
  always_comb begin
    cur_best  = best_r;
    cur_bestv = bestv_r;
    cur_below = below_r;
    if (pend_r == PEND_CTR) begin
      cur_best  = vidx_r;
      cur_bestv = s_rdata;
      cur_below = below_thr(s_rdata, thr_r);
    end else if (pend_r == PEND_NBR && s_rdata > bestv_r) begin
      cur_best  = pend_addr_r;
      cur_bestv = s_rdata;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && in_data.command == CMD_COMPUTE) begin
          state_nxt = ST_P1_CTR;
        end else if (in_fire && in_data.command == CMD_READ && in_vol) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ:     state_nxt = ST_IDLE;
      ST_P1_CTR:   state_nxt = ST_P1_NBR;
      ST_P1_NBR: begin
        if (o_last) begin
          state_nxt = ST_P1_LAST;
        end
      end
      ST_P1_LAST:  state_nxt = vox_last ? ST_CLEAR : ST_P1_CTR;
      ST_CLEAR: begin
        if (i_last) begin
          state_nxt = ST_P3_START;
        end
      end
      ST_P3_START: state_nxt = ST_P3_CHK;
      ST_P3_CHK: begin
        if (below_thr(s_rdata, thr_r)) begin
          state_nxt = i_last ? ST_DONE : ST_P3_START;
        end else if (u_rdata == i_r[IDX_W-1:0]) begin
          state_nxt = ST_P3_ROOT;
        end else begin
          state_nxt = ST_P3_CHASE;
        end
      end
      ST_P3_CHASE: begin
        if (u_rdata == r_r) begin
          state_nxt = ST_P3_ROOT;
        end
      end
      ST_P3_ROOT:  state_nxt = i_last ? ST_DONE : ST_P3_START;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and result beat.
  always_comb begin
    a_nxt = a_r;  b_nxt = b_r;  d_nxt = d_r;
    vidx_nxt = vidx_r;
    o0_nxt = o0_r;  o1_nxt = o1_r;  o2_nxt = o2_r;
    pend_nxt = PEND_NONE;
    pend_addr_nxt = pend_addr_r;
    best_nxt = best_r;  bestv_nxt = bestv_r;  below_nxt = below_r;
    i_nxt = i_r;  r_nxt = r_r;  c_nxt = c_r;
    regions_nxt = regions_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    s_we = 1'b0;  s_waddr = IDX_W'(in_data.voxel_index);
    s_wdata = SAMPLE_BITS'(in_data.sample_value);
    s_raddr = vidx_r;
    u_we = 1'b0;  u_waddr = vidx_r;  u_wdata = cur_below ? vidx_r : cur_best;
    u_raddr = i_r[IDX_W-1:0];
    rt_we = 1'b0;  rt_waddr = i_r[IDX_W-1:0];  rt_wdata = '0;  rt_raddr = r_r;
    l_we = 1'b0;  l_waddr = i_r[IDX_W-1:0];  l_wdata = '0;
    l_raddr = IDX_W'(in_data.voxel_index);

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.command)
            CMD_WRITE: begin
              s_we = in_vol;
              out_nxt = '{label: '0, region_count: regions_r, status: !in_vol};
              out_valid_nxt = 1'b1;
            end
            CMD_COMPUTE: begin
              a_nxt = '0;  b_nxt = '0;  d_nxt = '0;  vidx_nxt = '0;
              i_nxt = '0;  c_nxt = '0;
            end
            CMD_READ: begin
              if (!in_vol) begin
                out_nxt = '{label: '0, region_count: regions_r, status: 1'b1};
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_nxt = '{label: '0, region_count: regions_r, status: 1'b0};
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        out_nxt = '{label: l_rdata, region_count: regions_r, status: 1'b0};
        out_valid_nxt = 1'b1;
      end
      ST_P1_CTR: begin
        s_raddr = vidx_r;
        pend_nxt = PEND_CTR;
        o0_nxt = OFF_NEG;  o1_nxt = OFF_NEG;  o2_nxt = OFF_NEG;
      end
      ST_P1_NBR: begin
        best_nxt = cur_best;  bestv_nxt = cur_bestv;  below_nxt = cur_below;
        s_raddr = jaddr;
        pend_nxt = nbr_ok ? PEND_NBR : PEND_NONE;
        pend_addr_nxt = jaddr;
        // Step through the offsets with the fast axis innermost.
        if (o2_r != OFF_POS) begin
          o2_nxt = o2_r + 2'd1;
        end else begin
          o2_nxt = OFF_NEG;
          if (o1_r != OFF_POS) begin
            o1_nxt = o1_r + 2'd1;
          end else begin
            o1_nxt = OFF_NEG;
            o0_nxt = o0_r + 2'd1;
          end
        end
      end
      ST_P1_LAST: begin
        u_we = 1'b1;
        vidx_nxt = vidx_r + IDX_W'(1);
        if (d_last) begin
          d_nxt = '0;
          if (b_last) begin
            b_nxt = '0;
            a_nxt = a_r + COORD_W'(1);
          end else begin
            b_nxt = b_r + COORD_W'(1);
          end
        end else begin
          d_nxt = d_r + COORD_W'(1);
        end
        if (vox_last) begin
          i_nxt = '0;
        end
      end
      ST_CLEAR: begin
        rt_we = 1'b1;
        i_nxt = i_last ? '0 : i_r + CNT_W'(1);
      end
      ST_P3_START: begin
        s_raddr = i_r[IDX_W-1:0];
        u_raddr = i_r[IDX_W-1:0];
      end
      ST_P3_CHK: begin
        if (below_thr(s_rdata, thr_r)) begin
          l_we = 1'b1;
          i_nxt = i_r + CNT_W'(1);
        end else if (u_rdata == i_r[IDX_W-1:0]) begin
          r_nxt = i_r[IDX_W-1:0];
          rt_raddr = i_r[IDX_W-1:0];
        end else begin
          r_nxt = u_rdata;
          u_raddr = u_rdata;
        end
      end
      ST_P3_CHASE: begin
        if (u_rdata == r_r) begin
          rt_raddr = r_r;
        end else begin
          r_nxt = u_rdata;
          u_raddr = u_rdata;
        end
      end
      ST_P3_ROOT: begin
        l_we = 1'b1;
        i_nxt = i_r + CNT_W'(1);
        if (rt_rdata == '0) begin
          // First voxel that reaches this maximum opens a new region.
          c_nxt = c_r + LABEL_W'(1);
          rt_we = 1'b1;
          rt_waddr = r_r;
          rt_wdata = c_r + LABEL_W'(1);
          l_wdata = c_r + LABEL_W'(1);
        end else begin
          l_wdata = rt_rdata;
        end
      end
      ST_DONE: begin
        regions_nxt = c_r;
        out_nxt = '{label: '0, region_count: c_r, status: 1'b0};
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      regions_r   <= '0;
      size_slow_r <= CFG_EXT_W'(16);
      size_mid_r  <= CFG_EXT_W'(16);
      size_fast_r <= CFG_EXT_W'(16);
      thr_r       <= '0;
      pend_r      <= PEND_NONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      regions_r   <= regions_nxt;
      pend_r      <= pend_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SIZE_SLOW: size_slow_r <= cfg_data[CFG_EXT_W-1:0];
          CFG_SIZE_MID:  size_mid_r  <= cfg_data[CFG_EXT_W-1:0];
          CFG_SIZE_FAST: size_fast_r <= cfg_data[CFG_EXT_W-1:0];
          CFG_THRESHOLD: thr_r       <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    d_r         <= d_nxt;
    vidx_r      <= vidx_nxt;
    o0_r        <= o0_nxt;
    o1_r        <= o1_nxt;
    o2_r        <= o2_nxt;
    pend_addr_r <= pend_addr_nxt;
    best_r      <= best_nxt;
    bestv_r     <= bestv_nxt;
    below_r     <= below_nxt;
    i_r         <= i_nxt;
    r_r         <= r_nxt;
    c_r         <= c_nxt;
  end

  // Samples, uphill links, root region numbers and labels.
  wrl3d_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_VOXELS)) u_sample_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  wrl3d_ram #(.WIDTH(IDX_W), .DEPTH(MAX_VOXELS)) u_uphill_ram (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  wrl3d_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_VOXELS)) u_root_ram (
    .clk(clk), .we(rt_we), .waddr(rt_waddr), .wdata(rt_wdata),
    .raddr(rt_raddr), .rdata(rt_rdata)
  );

  wrl3d_ram #(.WIDTH(LABEL_W), .DEPTH(MAX_VOXELS)) u_link_ram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata)
  );

  // Checks on the sequencer.
  `WRL_ASSERT_NXT(a_compute_start, in_fire && in_data.command == CMD_COMPUTE, state_r == ST_P1_CTR)
  `WRL_ASSERT_IMP(a_busy_no_beat, state_r != ST_IDLE, !in_ready)
  `WRL_ASSERT_IMP(a_count_bound, state_r == ST_P3_ROOT, CNT_W'(c_r) <= i_r)
  `WRL_ASSERT_IMP(a_chase_range, state_r == ST_P3_CHASE, CNT_W'(r_r) < vol)

endmodule

// ===== bench/watershed_region_labeler_3d_core_tb.sv =====
module watershed_region_labeler_3d_core_tb;
  import wrl3d_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Command code that the block answers without changing its state.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = CFG_SIZE_SLOW;
  logic [THR_W-1:0] cfg_data = '0;

  watershed_region_labeler_3d_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Local copy of the block's state and registers.
  logic [15:0] samples [MAX_VOXELS];
  logic [12:0] labels [MAX_VOXELS];
  bit sample_written [MAX_VOXELS];
  bit label_valid [MAX_VOXELS];
  int uphill [MAX_VOXELS];
  int root_num [MAX_VOXELS];
  logic [12:0] region_total;
  logic [4:0] ext_slow_reg, ext_mid_reg, ext_fast_reg;
  logic [15:0] level_reg;

  out_t expected_beats[$];
  int fail_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  function automatic int eff_extent(logic [4:0] r);
    if (r == 0) return 1;
    if (r > MAX_EXTENT) return MAX_EXTENT;
    return r;
  endfunction

  function automatic int vol_size();
    return eff_extent(ext_slow_reg) * eff_extent(ext_mid_reg) * eff_extent(ext_fast_reg);
  endfunction

  // Steepest-ascent linking followed by chain collapse to the local maxima.
  function automatic logic [12:0] label_regions();
    int n0, n1, n2, total, best, p0, p1, p2, j, r, steps, cnt;
    logic [15:0] bestv;
    n0 = eff_extent(ext_slow_reg);
    n1 = eff_extent(ext_mid_reg);
    n2 = eff_extent(ext_fast_reg);
    total = n0 * n1 * n2;
    cnt = 0;
    for (int a = 0; a < n0; a++)
      for (int b = 0; b < n1; b++)
        for (int d = 0; d < n2; d++) begin
          best = (a * n1 + b) * n2 + d;
          bestv = samples[best];
          if (bestv >= level_reg) begin
            for (int o0 = -1; o0 <= 1; o0++)
              for (int o1 = -1; o1 <= 1; o1++)
                for (int o2 = -1; o2 <= 1; o2++) begin
                  p0 = a + o0;
                  p1 = b + o1;
                  p2 = d + o2;
                  if (p0 >= 0 && p0 < n0 && p1 >= 0 && p1 < n1 && p2 >= 0 && p2 < n2) begin
                    j = (p0 * n1 + p1) * n2 + p2;
                    if (samples[j] > bestv) begin
                      best = j;
                      bestv = samples[j];
                    end
                  end
                end
          end
          uphill[(a * n1 + b) * n2 + d] = best;
        end
    for (int i = 0; i < MAX_VOXELS; i++) root_num[i] = 0;
    for (int i = 0; i < total; i++) begin
      label_valid[i] = 1'b1;
      if (samples[i] < level_reg) begin
        labels[i] = '0;
      end else begin
        r = i;
        steps = 0;
        while (uphill[r] != r && steps < total) begin
          r = uphill[r];
          steps++;
        end
        if (root_num[r] == 0) begin
          cnt++;
          root_num[r] = cnt;
        end
        labels[i] = 13'(root_num[r]);
      end
    end
    return 13'(cnt);
  endfunction

  // Updates the local state for one command and returns the result beat it gives.
  function automatic out_t predict_beat(in_t it);
    out_t res;
    bit in_vol;
    in_vol = int'(it.voxel_index) < vol_size();
    res = '0;
    case (it.command)
      CMD_WRITE: begin
        if (in_vol) begin
          samples[it.voxel_index] = it.sample_value;
          sample_written[it.voxel_index] = 1'b1;
        end else begin
          res.status = 1'b1;
        end
      end
      CMD_COMPUTE: begin
        region_total = label_regions();
      end
      CMD_READ: begin
        if (in_vol) res.label = labels[it.voxel_index];
        else res.status = 1'b1;
      end
      default: ;
    endcase
    res.region_count = region_total;
    return res;
  endfunction

  // Sends one beat; called right after a rising edge, returns right after the accepting edge.
  task automatic send_item(logic [1:0] cmd, int idx, logic [15:0] val);
    in_t it;
    it.command = cmd;
    it.voxel_index = 12'(idx);
    it.sample_value = val;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    expected_beats.push_back(predict_beat(it));
    items_sent++;
    in_valid <= 1'b1;
    in_data <= it;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Waits for every outstanding result, then idles before returning.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SIZE_SLOW: ext_slow_reg = val[4:0];
      CFG_SIZE_MID: ext_mid_reg = val[4:0];
      CFG_SIZE_FAST: ext_fast_reg = val[4:0];
      default: level_reg = val;
    endcase
  endtask

  task automatic set_volume(int s, int m, int f);
    write_reg(CFG_SIZE_SLOW, {11'($urandom), 5'(s)});
    write_reg(CFG_SIZE_MID, {11'($urandom), 5'(m)});
    write_reg(CFG_SIZE_FAST, {11'($urandom), 5'(f)});
  endtask

  // A command the block answers without touching its state, or an access outside the volume.
  task automatic send_noise();
    int v;
    v = vol_size();
    if (v >= MAX_VOXELS || $urandom_range(2) == 0) begin
      send_item(CMD_UNUSED, $urandom_range(4095), 16'($urandom));
    end else begin
      send_item($urandom_range(1) ? CMD_WRITE : CMD_READ, $urandom_range(4095, v),
                16'($urandom));
    end
  endtask

  // Result checker: a beat moves at the next rising edge when both sides are high here.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, out_data);
        fail_count++;
      end else begin
        out_t want;
        want = expected_beats.pop_front();
        if (out_data.label !== want.label) begin
          $display("%0t: label expected %0d actual %0d", $time, want.label, out_data.label);
          fail_count++;
        end
        if (out_data.region_count !== want.region_count) begin
          $display("%0t: region_count expected %0d actual %0d", $time,
                   want.region_count, out_data.region_count);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Reset defaults, degenerate and saturated extents, thresholds and every command.
  task automatic test_directed();
    logic [15:0] vals [12];
    send_item(CMD_UNUSED, 4095, 16'hFFFF);
    send_item(CMD_WRITE, 4095, 16'h0000);
    set_volume(0, 0, 0);
    send_item(CMD_WRITE, 0, 16'hFFFF);
    send_item(CMD_WRITE, 1, 16'h1234);
    send_item(CMD_READ, 4095, 16'h0);
    send_item(CMD_COMPUTE, 0, 16'h0);
    send_item(CMD_READ, 0, 16'h0);
    // Two peaks, a plateau tie and voxels below threshold.
    set_volume(2, 3, 2);
    write_reg(CFG_THRESHOLD, 16'h8000);
    vals = '{16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h9000, 16'h9000,
             16'h8001, 16'hA000, 16'h0001, 16'hC000, 16'h8000, 16'hFFFE};
    for (int i = 0; i < 12; i++) send_item(CMD_WRITE, i, vals[i]);
    send_item(CMD_COMPUTE, 0, 16'h0);
    for (int i = 0; i < 12; i++) send_item(CMD_READ, i, 16'h0);
    // Saturated extent along the slow axis with the highest threshold.
    set_volume(31, 1, 0);
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    for (int i = 0; i < 16; i++) send_item(CMD_WRITE, i, (i % 5 == 0) ? 16'hFFFF : 16'(i));
    send_item(CMD_COMPUTE, 0, 16'h0);
    for (int i = 0; i < 16; i++) send_item(CMD_READ, i, 16'h0);
    send_item(CMD_READ, 16, 16'h0);
    write_reg(CFG_THRESHOLD, 16'h0000);
    send_item(CMD_COMPUTE, 0, 16'h0);
    send_item(CMD_READ, 15, 16'h0);
  endtask

  // Random volumes: fill, compute, read back, sometimes resize and read the old labels.
  task automatic test_random(int quota);
    int goal, v, idx, pick;
    logic [15:0] lo;
    goal = items_sent + quota;
    while (items_sent < goal) begin
      pick = $urandom_range(9);
      if (pick == 0) set_volume($urandom_range(31, 17), $urandom_range(1), $urandom_range(2));
      else if (pick == 1) set_volume(16, $urandom_range(4), 1);
      else set_volume($urandom_range(4), $urandom_range(4), $urandom_range(4));
      pick = $urandom_range(4);
      lo = (pick == 0) ? 16'h0 : (pick == 1) ? 16'hFFFF : 16'($urandom);
      write_reg(CFG_THRESHOLD, lo);
      v = vol_size();
      pick = $urandom_range(2);
      for (int i = 0; i < v; i++) begin
        if (!sample_written[i] || $urandom_range(3) != 0) begin
          if (pick == 0) send_item(CMD_WRITE, i, 16'($urandom));
          else if (pick == 1) send_item(CMD_WRITE, i, 16'($urandom_range(7)) + lo - 16'd3);
          else send_item(CMD_WRITE, i, 16'($urandom_range(3)) * 16'h5555);
        end
        if ($urandom_range(9) == 0) send_noise();
      end
      send_item(CMD_COMPUTE, $urandom_range(4095), 16'($urandom));
      repeat ($urandom_range(12, 3)) begin
        if ($urandom_range(4) == 0) send_noise();
        else send_item(CMD_READ, $urandom_range(v - 1), 16'($urandom));
      end
      if ($urandom_range(3) == 0) begin
        set_volume($urandom_range(4), $urandom_range(4), $urandom_range(4));
        v = vol_size();
        repeat (6) begin
          idx = $urandom_range(v - 1);
          if (label_valid[idx]) send_item(CMD_READ, idx, 16'h0);
          else send_noise();
        end
      end
    end
  endtask

  initial begin
    for (int i = 0; i < MAX_VOXELS; i++) begin
      samples[i] = '0;
      labels[i] = '0;
      sample_written[i] = 1'b0;
      label_valid[i] = 1'b0;
    end
    region_total = '0;
    ext_slow_reg = 5'd16;
    ext_mid_reg = 5'd16;
    ext_fast_reg = 5'd16;
    level_reg = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_idle_pct = 28;
    recv_stall_pct = 74;
    test_directed();
    test_random(450);
    send_idle_pct = 74;
    recv_stall_pct = 28;
    test_random(450);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_random(450);
    wait_drained();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
